// File: src/qpd_pkg.sv
// Shared definitions for the quoted-printable decoder.
// Holds result kind codes, input function codes, the escape character and hex lookup.
// No dependencies.
package qpd_pkg;

   // Input item function codes (code 3 acts as a token)
   localparam logic [1:0] FUNC_DATA  = 2'd0;
   localparam logic [1:0] FUNC_EOL   = 2'd1;
   localparam logic [1:0] FUNC_TOKEN = 2'd2;

   // Result kind codes
   localparam logic [2:0] KIND_DATA   = 3'd0;
   localparam logic [2:0] KIND_EOL    = 3'd1;
   localparam logic [2:0] KIND_TOKEN  = 3'd2;
   localparam logic [2:0] KIND_NOLINE = 3'd3;
   localparam logic [2:0] KIND_BADESC = 3'd4;

   // Most results one transaction can produce
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] ESC_CHAR = 8'h3D;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Map an ASCII hex digit (either case) to its value
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.ok    = 1'b0;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok    = 1'b1;
         r.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.ok    = 1'b1;
         r.value = c[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

// File: src/quoted_printable_decoder.sv
// Top level of the quoted-printable decoder: input register, escape state,
// result buffer of up to three results. Depends on qpd_pkg.
//
// The decoder takes one transaction per cycle and emits one result per
// cycle while rsp_ready is high. Each input transaction lands in an input
// register; the escape logic decodes it combinationally into zero to three
// results, which are loaded into a small result buffer and drained one per
// cycle while rsp_ready is high. Transactions that cause zero or one result
// sustain one per cycle; one that causes two or three results holds the
// single result port until all are taken, which sets the rate. A new
// transaction is taken while results of the previous one still wait, but
// once the input register is full a stalled output stalls the input.
// Results of one transaction come out in order, the final one with rsp_last.
module quoted_printable_decoder
   import qpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_EQ     = 2'd1,
      MODE_DIGIT  = 2'd2,
      MODE_SOFT   = 2'd3
   } mode_type;

   localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);

   // Input register
   logic       in_vld_ff;
   logic [1:0] in_func_ff;
   logic [7:0] in_char_ff;

   // Escape state
   mode_type   mode_ff, mode_in;
   logic [3:0] nib_ff, nib_in;

   // Result buffer, slot 0 is presented
   logic [CntW-1:0] rem_ff;
   logic [2:0]      kind_ff [MAX_RESULTS];
   logic [7:0]      byte_ff [MAX_RESULTS];

   // Decoded results for the transaction in the input register
   logic [CntW-1:0] n_dec;
   logic [2:0]      kind_dec [MAX_RESULTS];
   logic [7:0]      byte_dec;

   logic          rsp_take;
   logic          move;
   logic          is_data, is_eol, is_tok;
   hex_digit_type hex;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign move      = in_vld_ff &&
                      (rem_ff == '0 || (rem_ff == CntW'(1) && rsp_ready));
   assign req_ready = !in_vld_ff || move;

   assign rsp_valid    = rem_ff != '0;
   assign rsp_out_kind = kind_ff[0];
   assign rsp_out_byte = byte_ff[0];
   assign rsp_last     = rem_ff == CntW'(1);

   assign is_data = in_func_ff == FUNC_DATA;
   assign is_eol  = in_func_ff == FUNC_EOL;
   assign is_tok  = in_func_ff[1];
   assign hex     = hex_decode(in_char_ff);

   // Decode one transaction against the escape state
   always_comb begin
      n_dec       = '0;
      kind_dec[0] = KIND_DATA;
      kind_dec[1] = KIND_DATA;
      kind_dec[2] = KIND_DATA;
      byte_dec    = 8'd0;
      mode_in     = mode_ff;
      nib_in      = nib_ff;
      unique case (mode_ff)
         MODE_EQ: begin
            if (is_data) begin
               if (hex.ok) begin
                  nib_in  = hex.value;
                  mode_in = MODE_DIGIT;
               end else begin
                  n_dec       = CntW'(1);
                  kind_dec[0] = KIND_BADESC;
                  mode_in     = MODE_NORMAL;
               end
            end else if (is_eol) begin
               mode_in = MODE_SOFT;
            end else begin
               n_dec       = CntW'(2);
               kind_dec[0] = KIND_BADESC;
               kind_dec[1] = KIND_TOKEN;
               mode_in     = MODE_NORMAL;
            end
         end
         MODE_DIGIT: begin
            mode_in = MODE_NORMAL;
            if (is_data) begin
               n_dec = CntW'(1);
               if (hex.ok) begin
                  kind_dec[0] = KIND_DATA;
                  byte_dec    = {nib_ff, hex.value};
               end else begin
                  kind_dec[0] = KIND_BADESC;
               end
            end else begin
               n_dec       = CntW'(2);
               kind_dec[0] = KIND_BADESC;
               kind_dec[1] = is_eol ? KIND_EOL : KIND_TOKEN;
            end
         end
         MODE_NORMAL, MODE_SOFT: begin
            mode_in = MODE_NORMAL;
            if (is_tok && mode_ff == MODE_SOFT) begin
               // stream ended after a soft break
               n_dec       = CntW'(3);
               kind_dec[0] = KIND_EOL;
               kind_dec[1] = KIND_TOKEN;
               kind_dec[2] = KIND_NOLINE;
            end else if (is_data) begin
               if (in_char_ff == ESC_CHAR) begin
                  mode_in = MODE_EQ;
               end else begin
                  n_dec       = CntW'(1);
                  kind_dec[0] = KIND_DATA;
                  byte_dec    = in_char_ff;
               end
            end else begin
               n_dec       = CntW'(1);
               kind_dec[0] = is_eol ? KIND_EOL : KIND_TOKEN;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase
   end

   // Hold the input transaction until it is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_char_ff <= req_char_in;
      end
   end

   // Advance escape state and load or shift the result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         nib_ff  <= 4'd0;
         rem_ff  <= '0;
      end else if (move) begin
         mode_ff <= mode_in;
         nib_ff  <= nib_in;
         rem_ff  <= n_dec;
      end else if (rsp_take) begin
         rem_ff <= rem_ff - CntW'(1);
      end
      if (move) begin
         kind_ff[0] <= kind_dec[0];
         kind_ff[1] <= kind_dec[1];
         kind_ff[2] <= kind_dec[2];
         byte_ff[0] <= byte_dec;
         byte_ff[1] <= 8'd0;
         byte_ff[2] <= 8'd0;
      end else if (rsp_take) begin
         kind_ff[0] <= kind_ff[1];
         kind_ff[1] <= kind_ff[2];
         byte_ff[0] <= byte_ff[1];
         byte_ff[1] <= byte_ff[2];
      end
   end

   // Only data results carry a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_DATA |-> rsp_out_byte == 8'd0)
      else $error("non-data result carries a byte");

   // A non-final result is followed by another result of the same transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("results of one transaction broken up");

   // The continuation error always closes its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_NOLINE |-> rsp_last)
      else $error("continuation error not final");

   // The buffer never holds more than one transaction's results
   assert property (@(posedge clock) disable iff (reset)
      rem_ff <= CntW'(MAX_RESULTS))
      else $error("result buffer overfilled");

endmodule
